// ===== hw/rtl/srtf_pkg.sv =====
// Shared types and constants for the shortest-remaining-time-first scheduler.
// Used by srtf_slot_table and srtf_preemptive_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int TIME_W  = 16;
    localparam int BURST_W = 12;
    localparam int SUM_W   = 19;
    localparam int COUNT_W = 4;
    localparam int RSLOT_W = 3;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_TURN,
        ST_WAIT,
        ST_TOTAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [BURST_W-1:0] rem;
        logic [BURST_W-1:0] orig;
        logic [TIME_W-1:0]  arr;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t entry;
    } table_wr_t;

    typedef struct packed {
        logic   live;
        entry_t entry;
    } table_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srtf_slot_table.sv =====
// Process slot table: one write port, one registered read port, per-slot live bits.
// Depends on srtf_pkg for the entry and port structs.
`timescale 1ns / 1ps
`default_nettype none

module srtf_slot_table #(
    parameter int NUM_SLOTS = 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          clear,
    input  srtf_pkg::table_wr_t          wr,
    input  wire [$clog2(NUM_SLOTS)-1:0]  waddr,
    input  wire [$clog2(NUM_SLOTS)-1:0]  raddr,
    output srtf_pkg::table_rd_t          rd
);

    srtf_pkg::entry_t       mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   live_reg;
    srtf_pkg::table_rd_t    rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (clear)
        begin
            live_reg <= '0;
        end
        else if (wr.en)
        begin
            live_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[waddr] <= wr.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg.entry <= mem[raddr];
        rd_reg.live  <= live_reg[raddr];
    end

    assign rd = rd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/srtf_preemptive_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Depends on srtf_pkg and srtf_slot_table.
//
// Usage:
//   Drive action, slot, arrival and burst and raise start; the beat is taken
//   on a rising edge with start high and busy low. busy stays high until the
//   result has been shown. Every beat gives exactly one result, shown for one
//   cycle with done high; the receiver cannot stall it and must take it then.
//   Load, clear and the unused action code go from idle straight to done.
//   A tick scans the slot table one entry per cycle through a single
//   registered read port and one compare unit, then passes drain and
//   update, plus turn, wait and total when the running slot completes
//   (turnaround, waiting and the two totals go through one subtract/add step each).
//   A new beat can be accepted in the cycle after done.
//   Reset, or a clear beat, empties the table (per-slot live bits drop at
//   once), and zeroes time, segment tracking and totals; no sweep is needed.
//   Time saturates at its maximum, totals and the completion count saturate.
`timescale 1ns / 1ps
`default_nettype none

module srtf_preemptive_scheduler #(
    parameter int NUM_SLOTS = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    output logic                                done,
    input  wire [1:0]                           action,
    input  wire [srtf_pkg::RSLOT_W-1:0]         slot,
    input  wire [srtf_pkg::TIME_W-1:0]          arrival,
    input  wire [srtf_pkg::BURST_W-1:0]         burst,
    output logic                                run_valid,
    output logic [srtf_pkg::RSLOT_W-1:0]        run_slot,
    output logic                                new_segment,
    output logic [srtf_pkg::TIME_W-1:0]         segment_start,
    output logic                                finished,
    output logic [srtf_pkg::TIME_W-1:0]         finish_time,
    output logic [srtf_pkg::TIME_W-1:0]         turnaround,
    output logic [srtf_pkg::TIME_W-1:0]         waiting,
    output logic [srtf_pkg::SUM_W-1:0]          total_turnaround,
    output logic [srtf_pkg::SUM_W-1:0]          total_waiting,
    output logic [srtf_pkg::COUNT_W-1:0]        finished_count
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    srtf_pkg::state_t state_reg, state_next;

    logic [IW-1:0]                   scan_idx_reg;
    logic [IW-1:0]                   cmp_idx_reg;
    logic                            cmp_vld_reg;
    logic                            found_reg;
    logic [IW-1:0]                   best_idx_reg;
    srtf_pkg::entry_t                best_reg;

    logic [srtf_pkg::TIME_W-1:0]     now_reg;
    logic [srtf_pkg::RSLOT_W-1:0]    last_slot_reg;
    logic                            last_valid_reg;
    logic [srtf_pkg::SUM_W-1:0]      sum_tat_reg;
    logic [srtf_pkg::SUM_W-1:0]      sum_wt_reg;
    logic [srtf_pkg::COUNT_W-1:0]    count_reg;

    logic                            res_run_valid_reg;
    logic [srtf_pkg::RSLOT_W-1:0]    res_run_slot_reg;
    logic                            res_new_seg_reg;
    logic [srtf_pkg::TIME_W-1:0]     res_seg_start_reg;
    logic                            res_finished_reg;
    logic [srtf_pkg::TIME_W-1:0]     res_finish_time_reg;
    logic [srtf_pkg::TIME_W-1:0]     res_tat_reg;
    logic [srtf_pkg::TIME_W-1:0]     res_wt_reg;

    logic                            accept;
    logic                            load_ok;
    logic                            table_clear;
    srtf_pkg::table_wr_t             tbl_wr;
    logic [IW-1:0]                   tbl_waddr;
    srtf_pkg::table_rd_t             tbl_rd;

    logic                            candidate;
    logic [srtf_pkg::TIME_W-1:0]     now_inc;
    logic [srtf_pkg::SUM_W:0]        tat_sum;
    logic [srtf_pkg::SUM_W:0]        wt_sum;

    assign accept  = start && !busy;
    assign load_ok = (32'(slot) < 32'(NUM_SLOTS));
    assign table_clear = accept && (action == srtf_pkg::ACT_CLEAR);

    srtf_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (table_clear),
        .wr    (tbl_wr),
        .waddr (tbl_waddr),
        .raddr (scan_idx_reg),
        .rd    (tbl_rd)
    );

    // table write: load beat or decrement of the picked slot
    always_comb
    begin
        tbl_wr    = '0;
        tbl_waddr = best_idx_reg;
        if (state_reg == srtf_pkg::ST_IDLE)
        begin
            tbl_waddr          = IW'(slot);
            tbl_wr.en          = accept && (action == srtf_pkg::ACT_LOAD) && load_ok;
            tbl_wr.entry.rem   = burst;
            tbl_wr.entry.orig  = burst;
            tbl_wr.entry.arr   = arrival;
        end
        else if (state_reg == srtf_pkg::ST_UPDATE)
        begin
            tbl_wr.en          = found_reg;
            tbl_wr.entry.rem   = best_reg.rem - srtf_pkg::BURST_W'(1);
            tbl_wr.entry.orig  = best_reg.orig;
            tbl_wr.entry.arr   = best_reg.arr;
        end
    end

    // shared compare unit
    assign candidate = cmp_vld_reg && tbl_rd.live
                       && (tbl_rd.entry.rem != '0)
                       && (tbl_rd.entry.arr <= now_reg)
                       && (!found_reg || (tbl_rd.entry.rem < best_reg.rem));

    assign now_inc = (now_reg == srtf_pkg::TIME_MAX) ? now_reg
                                                     : now_reg + srtf_pkg::TIME_W'(1);
    assign tat_sum = {1'b0, sum_tat_reg} + (srtf_pkg::SUM_W + 1)'(res_tat_reg);
    assign wt_sum  = {1'b0, sum_wt_reg} + (srtf_pkg::SUM_W + 1)'(res_wt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == srtf_pkg::ACT_TICK) ? srtf_pkg::ST_SCAN
                                                                 : srtf_pkg::ST_DONE;
                end
            end
            srtf_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = srtf_pkg::ST_DRAIN;
                end
            end
            srtf_pkg::ST_DRAIN:  state_next = srtf_pkg::ST_UPDATE;
            srtf_pkg::ST_UPDATE:
            begin
                state_next = (found_reg && (best_reg.rem == srtf_pkg::BURST_W'(1)))
                             ? srtf_pkg::ST_TURN : srtf_pkg::ST_DONE;
            end
            srtf_pkg::ST_TURN:   state_next = srtf_pkg::ST_WAIT;
            srtf_pkg::ST_WAIT:   state_next = srtf_pkg::ST_TOTAL;
            srtf_pkg::ST_TOTAL:  state_next = srtf_pkg::ST_DONE;
            srtf_pkg::ST_DONE:   state_next = srtf_pkg::ST_IDLE;
            default:             state_next = srtf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy = (state_reg != srtf_pkg::ST_IDLE);
        done = (state_reg == srtf_pkg::ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srtf_pkg::ST_IDLE;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            scan_idx_reg   <= '0;
            now_reg        <= '0;
            last_slot_reg  <= '0;
            last_valid_reg <= 1'b0;
            sum_tat_reg    <= '0;
            sum_wt_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == srtf_pkg::ST_SCAN);
            if (candidate)
            begin
                found_reg <= 1'b1;
            end
            unique case (state_reg)
                srtf_pkg::ST_IDLE:
                begin
                    scan_idx_reg <= '0;
                    found_reg    <= 1'b0;
                    if (table_clear)
                    begin
                        now_reg        <= '0;
                        last_slot_reg  <= '0;
                        last_valid_reg <= 1'b0;
                        sum_tat_reg    <= '0;
                        sum_wt_reg     <= '0;
                        count_reg      <= '0;
                    end
                end
                srtf_pkg::ST_SCAN:
                begin
                    if (scan_idx_reg != LAST_IDX)
                    begin
                        scan_idx_reg <= scan_idx_reg + IW'(1);
                    end
                end
                srtf_pkg::ST_UPDATE:
                begin
                    now_reg        <= now_inc;
                    last_valid_reg <= found_reg;
                    if (found_reg)
                    begin
                        last_slot_reg <= srtf_pkg::RSLOT_W'(best_idx_reg);
                    end
                end
                srtf_pkg::ST_WAIT:
                begin
                    sum_tat_reg <= tat_sum[srtf_pkg::SUM_W] ? '1
                                                            : tat_sum[srtf_pkg::SUM_W-1:0];
                end
                srtf_pkg::ST_TOTAL:
                begin
                    sum_wt_reg <= wt_sum[srtf_pkg::SUM_W] ? '1
                                                          : wt_sum[srtf_pkg::SUM_W-1:0];
                    if (count_reg != srtf_pkg::COUNT_MAX)
                    begin
                        count_reg <= count_reg + srtf_pkg::COUNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload: best pick and result fields
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (candidate)
        begin
            best_reg     <= tbl_rd.entry;
            best_idx_reg <= cmp_idx_reg;
        end
        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_run_valid_reg   <= 1'b0;
                    res_run_slot_reg    <= '0;
                    res_new_seg_reg     <= 1'b0;
                    res_seg_start_reg   <= '0;
                    res_finished_reg    <= 1'b0;
                    res_finish_time_reg <= '0;
                    res_tat_reg         <= '0;
                    res_wt_reg          <= '0;
                end
            end
            srtf_pkg::ST_UPDATE:
            begin
                res_seg_start_reg <= now_reg;
                if (found_reg)
                begin
                    res_run_valid_reg <= 1'b1;
                    res_run_slot_reg  <= srtf_pkg::RSLOT_W'(best_idx_reg);
                    res_new_seg_reg   <= !last_valid_reg
                                         || (last_slot_reg != srtf_pkg::RSLOT_W'(best_idx_reg));
                    res_finished_reg  <= (best_reg.rem == srtf_pkg::BURST_W'(1));
                end
            end
            srtf_pkg::ST_TURN:
            begin
                res_finish_time_reg <= now_reg;
                res_tat_reg <= (now_reg >= best_reg.arr) ? now_reg - best_reg.arr : '0;
            end
            srtf_pkg::ST_WAIT:
            begin
                res_wt_reg <= (res_tat_reg >= srtf_pkg::TIME_W'(best_reg.orig))
                              ? res_tat_reg - srtf_pkg::TIME_W'(best_reg.orig) : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign run_valid        = res_run_valid_reg;
    assign run_slot         = res_run_slot_reg;
    assign new_segment      = res_new_seg_reg;
    assign segment_start    = res_seg_start_reg;
    assign finished         = res_finished_reg;
    assign finish_time      = res_finish_time_reg;
    assign turnaround       = res_tat_reg;
    assign waiting          = res_wt_reg;
    assign total_turnaround = sum_tat_reg;
    assign total_waiting    = sum_wt_reg;
    assign finished_count   = count_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_busy_ends_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    a_finish_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> run_valid)
        else $error("completion reported on an idle tick");

    a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == srtf_pkg::ACT_TICK)) |=> (busy && !done))
        else $error("tick result shown before the scan");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srtf_pkg::ST_SCAN) |-> (32'(scan_idx_reg) < 32'(NUM_SLOTS)))
        else $error("scan index beyond the table");

endmodule

`default_nettype wire

// ===== tb/srtf_preemptive_scheduler_tb.sv =====
// Self-checking testbench for srtf_preemptive_scheduler: start/busy/done handshake,
// a built-in scheduling predictor and field-by-field result compare.
// Depends on srtf_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module srtf_preemptive_scheduler_tb;

    localparam int TIME_W  = srtf_pkg::TIME_W;
    localparam int BURST_W = srtf_pkg::BURST_W;
    localparam int SUM_W   = srtf_pkg::SUM_W;
    localparam int COUNT_W = srtf_pkg::COUNT_W;
    localparam int RSLOT_W = srtf_pkg::RSLOT_W;
    localparam logic [1:0] ACT_LOAD  = srtf_pkg::ACT_LOAD;
    localparam logic [1:0] ACT_TICK  = srtf_pkg::ACT_TICK;
    localparam logic [1:0] ACT_CLEAR = srtf_pkg::ACT_CLEAR;
    localparam logic [TIME_W-1:0]  TIME_MAX  = srtf_pkg::TIME_MAX;
    localparam logic [COUNT_W-1:0] COUNT_MAX = srtf_pkg::COUNT_MAX;

    localparam int NUM_SLOTS = 8;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BEATS = 1500;
    localparam int SAT_TICKS = 240;
    localparam int NO_PICK = 9999;
    localparam int MAX_GAP = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int TIMEOUT_NS = 4_000_000;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [1:0]         action;
        logic [RSLOT_W-1:0] slot;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        int                 gap;
        bit                 drain;
    } sched_beat_t;

    typedef struct packed {
        logic               run_valid;
        logic [RSLOT_W-1:0] run_slot;
        logic               new_segment;
        logic [TIME_W-1:0]  segment_start;
        logic               finished;
        logic [TIME_W-1:0]  finish_time;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
        logic [SUM_W-1:0]   total_turnaround;
        logic [SUM_W-1:0]   total_waiting;
        logic [COUNT_W-1:0] finished_count;
    } sched_result_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           action = ACT_LOAD;
    logic [RSLOT_W-1:0]   slot = '0;
    logic [TIME_W-1:0]    arrival = '0;
    logic [BURST_W-1:0]   burst = '0;
    logic                 busy;
    logic                 done;
    logic                 run_valid;
    logic [RSLOT_W-1:0]   run_slot;
    logic                 new_segment;
    logic [TIME_W-1:0]    segment_start;
    logic                 finished;
    logic [TIME_W-1:0]    finish_time;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    waiting;
    logic [SUM_W-1:0]     total_turnaround;
    logic [SUM_W-1:0]     total_waiting;
    logic [COUNT_W-1:0]   finished_count;

    sched_beat_t   pending_beats[$];
    sched_result_t pending_results[$];
    sched_beat_t   cur_beat;
    int            gap_left;
    int            beats_taken = 0;
    int            results_seen = 0;
    int            errors = 0;

    logic [BURST_W-1:0] model_rem [NUM_SLOTS];
    logic [BURST_W-1:0] model_orig [NUM_SLOTS];
    logic [TIME_W-1:0]  model_arr [NUM_SLOTS];
    logic [TIME_W-1:0]  model_time;
    logic [RSLOT_W-1:0] model_last_slot;
    logic               model_last_valid;
    logic [SUM_W-1:0]   model_sum_tat;
    logic [SUM_W-1:0]   model_sum_wt;
    logic [COUNT_W-1:0] model_done;
    int                 ticks_run = 0;
    int                 ticks_idle = 0;
    int                 completions = 0;
    int                 peak_time = 0;
    bit                 sums_saturated = 0;

    int plan_time = 0;
    int planned = 0;
    bit quiet_stretch = 0;

    srtf_preemptive_scheduler #(
        .NUM_SLOTS(NUM_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .action(action),
        .slot(slot),
        .arrival(arrival),
        .burst(burst),
        .run_valid(run_valid),
        .run_slot(run_slot),
        .new_segment(new_segment),
        .segment_start(segment_start),
        .finished(finished),
        .finish_time(finish_time),
        .turnaround(turnaround),
        .waiting(waiting),
        .total_turnaround(total_turnaround),
        .total_waiting(total_waiting),
        .finished_count(finished_count)
    );

    function automatic void clear_model();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            model_rem[i] = '0;
            model_orig[i] = '0;
            model_arr[i] = '0;
        end
        model_time = '0;
        model_last_slot = '0;
        model_last_valid = 1'b0;
        model_sum_tat = '0;
        model_sum_wt = '0;
        model_done = '0;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, int add);
        int s;
        s = acc + add;
        if (s >= SUM_MAX)
        begin
            sums_saturated = 1;
            return SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic sched_result_t step_scheduler(sched_beat_t b);
        sched_result_t r;
        int            least;
        int            pick;
        int            fin;
        int            tat;
        int            wt;
        bit            found;
        r = '0;
        case (b.action)
            ACT_LOAD:
            begin
                model_rem[b.slot] = b.burst;
                model_orig[b.slot] = b.burst;
                model_arr[b.slot] = b.arrival;
            end
            ACT_CLEAR:
                clear_model();
            ACT_TICK:
            begin
                least = NO_PICK;
                pick = 0;
                found = 0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (model_rem[i] != 0 && model_rem[i] < least && model_arr[i] <= model_time)
                    begin
                        least = model_rem[i];
                        pick = i;
                        found = 1;
                    end
                end
                r.segment_start = model_time;
                if (model_time != TIME_MAX)
                    model_time = model_time + 1'b1;
                if (model_time > peak_time)
                    peak_time = model_time;
                if (found)
                begin
                    r.run_valid = 1'b1;
                    r.run_slot = pick[RSLOT_W-1:0];
                    r.new_segment = !model_last_valid || model_last_slot != pick;
                    model_rem[pick] = model_rem[pick] - 1'b1;
                    if (model_rem[pick] == 0)
                    begin
                        fin = model_time;
                        tat = (fin >= model_arr[pick]) ? fin - model_arr[pick] : 0;
                        wt = (tat >= model_orig[pick]) ? tat - model_orig[pick] : 0;
                        r.finished = 1'b1;
                        r.finish_time = fin[TIME_W-1:0];
                        r.turnaround = tat[TIME_W-1:0];
                        r.waiting = wt[TIME_W-1:0];
                        model_sum_tat = sat_sum(model_sum_tat, tat);
                        model_sum_wt = sat_sum(model_sum_wt, wt);
                        if (model_done != COUNT_MAX)
                            model_done = model_done + 1'b1;
                        completions++;
                    end
                    model_last_slot = pick[RSLOT_W-1:0];
                    model_last_valid = 1'b1;
                    ticks_run++;
                end
                else
                begin
                    model_last_valid = 1'b0;
                    ticks_idle++;
                end
            end
            default:
                ;
        endcase
        r.total_turnaround = model_sum_tat;
        r.total_waiting = model_sum_wt;
        r.finished_count = model_done;
        return r;
    endfunction

    task automatic queue_beat(logic [1:0] act, int sl, int arr, int bur, bit drain);
        sched_beat_t b;
        b.action = act;
        b.slot = sl[RSLOT_W-1:0];
        b.arrival = arr[TIME_W-1:0];
        b.burst = bur[BURST_W-1:0];
        b.gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
        b.drain = drain;
        pending_beats.push_back(b);
        planned++;
        if (act == ACT_CLEAR)
            plan_time = 0;
        else if (act == ACT_TICK && plan_time < TIME_MAX)
            plan_time++;
    endtask

    task automatic queue_tick();
        queue_beat(ACT_TICK, $urandom_range(0, 7), $urandom_range(0, 65535),
            $urandom_range(0, 4095), 0);
    endtask

    function automatic int near_arrival();
        int r;
        int a;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(0, 65535);
        if (r < 3)
        begin
            a = plan_time - $urandom_range(0, 20);
            return (a < 0) ? 0 : a;
        end
        a = plan_time + $urandom_range(0, 8);
        return (a > TIME_MAX) ? TIME_MAX : a;
    endfunction

    function automatic int pick_burst();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(0, 4095);
        return $urandom_range(1, 12);
    endfunction

    task automatic random_scenario();
        int  loads;
        int  ticks;
        int  r;
        bit  hold;
        quiet_stretch = ($urandom_range(0, 3) == 0);
        hold = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0)
        begin
            queue_beat(ACT_CLEAR, $urandom_range(0, 7), $urandom_range(0, 65535),
                $urandom_range(0, 4095), hold);
            hold = 0;
        end
        loads = $urandom_range(1, NUM_SLOTS);
        for (int j = 0; j < loads; j++)
        begin
            queue_beat(ACT_LOAD, $urandom_range(0, 7), near_arrival(), pick_burst(), hold);
            hold = 0;
        end
        ticks = $urandom_range(5, 60);
        for (int j = 0; j < ticks; j++)
        begin
            r = $urandom_range(0, 19);
            if (r < 2)
                queue_beat(ACT_LOAD, $urandom_range(0, 7), near_arrival(),
                    $urandom_range(1, 6), 0);
            else if (r == 2)
                queue_beat(ACT_SPARE, $urandom_range(0, 7), $urandom_range(0, 65535),
                    $urandom_range(0, 4095), 0);
            else
                queue_tick();
        end
    endtask

    task automatic drive_next();
        cur_beat = pending_beats.pop_front();
        action <= cur_beat.action;
        slot <= cur_beat.slot;
        arrival <= cur_beat.arrival;
        burst <= cur_beat.burst;
        start <= 1'b1;
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else if (start && !busy)
        begin
            pending_results.push_back(step_scheduler(cur_beat));
            beats_taken <= beats_taken + 1;
            if (pending_beats.size() != 0 && pending_beats[0].gap == 0 && !pending_beats[0].drain)
                drive_next();
            else
            begin
                start <= 1'b0;
                gap_left = (pending_beats.size() != 0) ? pending_beats[0].gap : 0;
            end
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_beats.size() != 0
                     && (!pending_beats[0].drain || beats_taken == results_seen))
                drive_next();
        end
    end

    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with no command outstanding", $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("run_valid", want.run_valid, run_valid);
                compare_field("run_slot", want.run_slot, run_slot);
                compare_field("new_segment", want.new_segment, new_segment);
                compare_field("segment_start", want.segment_start, segment_start);
                compare_field("finished", want.finished, finished);
                compare_field("finish_time", want.finish_time, finish_time);
                compare_field("turnaround", want.turnaround, turnaround);
                compare_field("waiting", want.waiting, waiting);
                compare_field("total_turnaround", want.total_turnaround, total_turnaround);
                compare_field("total_waiting", want.total_waiting, total_waiting);
                compare_field("finished_count", want.finished_count, finished_count);
            end
            results_seen <= results_seen + 1;
        end
    end

    initial
    begin
        int goal;
        clear_model();

        // idle tick from reset, spare code, tie break, empty and future slots
        queue_tick();
        queue_beat(ACT_SPARE, 7, 65535, 4095, 0);
        queue_beat(ACT_LOAD, 0, 0, 3, 0);
        queue_beat(ACT_LOAD, 1, 0, 2, 0);
        queue_beat(ACT_LOAD, 2, 0, 2, 0);
        queue_beat(ACT_LOAD, 7, 65535, 4095, 0);
        queue_beat(ACT_LOAD, 3, 0, 0, 0);
        repeat (8) queue_tick();
        queue_beat(ACT_LOAD, 4, 0, 1, 0);
        queue_tick();
        queue_beat(ACT_LOAD, 5, plan_time + 2, 2, 0);
        repeat (4) queue_tick();
        queue_beat(ACT_CLEAR, 5, 65535, 4095, 1);
        queue_beat(ACT_LOAD, 0, 0, 5, 0);
        queue_tick();
        queue_beat(ACT_LOAD, 6, 0, 1, 0);
        repeat (2) queue_tick();

        goal = planned + RANDOM_BEATS;
        while (planned < goal)
            random_scenario();

        // back-to-back ticks over a fully loaded table with occasional reloads
        quiet_stretch = 1;
        queue_beat(ACT_CLEAR, 0, 0, 0, 1);
        for (int i = 0; i < NUM_SLOTS; i++)
            queue_beat(ACT_LOAD, i, $urandom_range(0, 200), $urandom_range(1, 4095), 0);
        for (int i = 0; i < SAT_TICKS; i++)
        begin
            if (i % 64 == 63)
                queue_beat(ACT_LOAD, $urandom_range(0, 7), $urandom_range(0, 65535),
                    $urandom_range(0, 4095), 0);
            queue_tick();
        end

        // short bursts on every slot, a late arrival, then clear and one more tick
        quiet_stretch = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            queue_beat(ACT_LOAD, i, 0, $urandom_range(1, 3), 0);
        repeat (30) queue_tick();
        queue_beat(ACT_LOAD, 3, 65535, 4, 0);
        repeat (6) queue_tick();
        queue_beat(ACT_CLEAR, 0, 0, 0, 0);
        queue_tick();

        @(negedge clk);
        while (pending_beats.size() != 0 || start || beats_taken != results_seen)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d busy ticks, %0d idle ticks, %0d completions.",
            beats_taken, ticks_run, ticks_idle, completions);
        $display("Peak time %0d, totals saturated: %0d.", peak_time, sums_saturated);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== srtf_preemptive_scheduler.f =====
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_slot_table.sv
hw/rtl/srtf_preemptive_scheduler.sv
tb/srtf_preemptive_scheduler_tb.sv
